[src/rect_topology_classifier_top_defines.svh]
`ifndef RECT_TOPOLOGY_CLASSIFIER_TOP_DEFINES_SVH
`define RECT_TOPOLOGY_CLASSIFIER_TOP_DEFINES_SVH

// implication checked on every clock edge outside reset
`define RTC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RTC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/rtc_pkg.sv]
package rtc_pkg;

  localparam int unsigned CoordBits = 32;
  localparam int unsigned CodeBits  = 4;

  typedef logic signed [CoordBits-1:0] coord_t;

  // interval relation of candidate s against reference r
  typedef enum logic [CodeBits-1:0] {
    RelNone         = 4'd0,
    RelAfter        = 4'd1,
    RelMetBy        = 4'd2,
    RelOverlappedBy = 4'd3,
    RelStartedBy    = 4'd4,
    RelContains     = 4'd5,
    RelFinishes     = 4'd6,
    RelEquals       = 4'd7,
    RelFinishedBy   = 4'd8,
    RelDuring       = 4'd9,
    RelStarts       = 4'd10,
    RelOverlaps     = 4'd11,
    RelMeets        = 4'd12,
    RelBefore       = 4'd13
  } rel_code_e;

  typedef struct packed {
    coord_t ref_x_low;
    coord_t ref_y_low;
    coord_t ref_x_high;
    coord_t ref_y_high;
    coord_t cand_x_low;
    coord_t cand_y_low;
    coord_t cand_x_high;
    coord_t cand_y_high;
  } req_t;

  typedef struct packed {
    logic                is_disjoint;
    logic                is_meet;
    logic                is_strict_overlap;
    logic                is_covers;
    logic                is_contains;
    logic                is_equal;
    logic                is_inside;
    logic                is_covered_by;
    logic [CodeBits-1:0] x_relation;
    logic [CodeBits-1:0] y_relation;
  } rsp_t;

  // per-axis comparator outcomes, s = candidate, r = reference
  typedef struct packed {
    logic slo_gt_rhi;
    logic slo_eq_rhi;
    logic slo_gt_rlo;
    logic slo_eq_rlo;
    logic shi_gt_rhi;
    logic shi_eq_rhi;
    logic shi_gt_rlo;
    logic shi_eq_rlo;
  } axis_cmp_t;

endpackage

[src/rtc_axis_cmp.sv]
module rtc_axis_cmp (
  input  rtc_pkg::coord_t    r_lo_i,
  input  rtc_pkg::coord_t    r_hi_i,
  input  rtc_pkg::coord_t    s_lo_i,
  input  rtc_pkg::coord_t    s_hi_i,
  output rtc_pkg::axis_cmp_t cmp_o,
  output rtc_pkg::rel_code_e code_o
);
  import rtc_pkg::*;

  axis_cmp_t c;
  logic      slo_lt_rhi, slo_lt_rlo, shi_lt_rhi;

  always_comb begin
    c.slo_gt_rhi = s_lo_i > r_hi_i;
    c.slo_eq_rhi = s_lo_i == r_hi_i;
    c.slo_gt_rlo = s_lo_i > r_lo_i;
    c.slo_eq_rlo = s_lo_i == r_lo_i;
    c.shi_gt_rhi = s_hi_i > r_hi_i;
    c.shi_eq_rhi = s_hi_i == r_hi_i;
    c.shi_gt_rlo = s_hi_i > r_lo_i;
    c.shi_eq_rlo = s_hi_i == r_lo_i;
  end

  assign slo_lt_rhi = !c.slo_gt_rhi && !c.slo_eq_rhi;
  assign slo_lt_rlo = !c.slo_gt_rlo && !c.slo_eq_rlo;
  assign shi_lt_rhi = !c.shi_gt_rhi && !c.shi_eq_rhi;
  assign cmp_o      = c;

  always_comb begin
    if (c.slo_gt_rhi) begin
      code_o = RelAfter;
    end else if (c.slo_eq_rhi) begin
      code_o = RelMetBy;
    end else if (c.shi_gt_rhi && c.slo_gt_rlo && slo_lt_rhi) begin
      code_o = RelOverlappedBy;
    end else if (c.shi_gt_rhi && c.slo_eq_rlo) begin
      code_o = RelStartedBy;
    end else if (c.shi_gt_rhi && slo_lt_rlo) begin
      code_o = RelContains;
    end else if (c.shi_eq_rhi && c.slo_gt_rlo) begin
      code_o = RelFinishes;
    end else if (c.shi_eq_rhi && c.slo_eq_rlo) begin
      code_o = RelEquals;
    end else if (c.shi_eq_rhi && slo_lt_rlo) begin
      code_o = RelFinishedBy;
    end else if (shi_lt_rhi && c.slo_gt_rlo) begin
      code_o = RelDuring;
    end else if (shi_lt_rhi && c.slo_eq_rlo) begin
      code_o = RelStarts;
    end else if (shi_lt_rhi && c.shi_gt_rlo && slo_lt_rlo) begin
      code_o = RelOverlaps;
    end else if (c.shi_eq_rlo) begin
      code_o = RelMeets;
    end else if (!c.shi_gt_rlo) begin
      code_o = RelBefore;
    end else begin
      code_o = RelNone;
    end
  end

endmodule

[src/rtc_classify.sv]
module rtc_classify (
  input  rtc_pkg::axis_cmp_t x_cmp_i,
  input  rtc_pkg::axis_cmp_t y_cmp_i,
  input  rtc_pkg::rel_code_e x_code_i,
  input  rtc_pkg::rel_code_e y_code_i,
  output rtc_pkg::rsp_t      rsp_o
);
  import rtc_pkg::*;

  logic overlap, meet, equal, contains, in_strict, encl_s, encl_r, covers, cov_by;

  function automatic logic ax_overlap(axis_cmp_t c);
    // not (r.lo > s.hi or s.lo > r.hi)
    return (c.shi_gt_rlo || c.shi_eq_rlo) && !c.slo_gt_rhi;
  endfunction

  always_comb begin
    overlap   = ax_overlap(x_cmp_i) && ax_overlap(y_cmp_i);
    meet      = overlap && (x_cmp_i.slo_eq_rhi || x_cmp_i.shi_eq_rlo ||
                            y_cmp_i.slo_eq_rhi || y_cmp_i.shi_eq_rlo);
    equal     = x_cmp_i.slo_eq_rlo && x_cmp_i.shi_eq_rhi &&
                y_cmp_i.slo_eq_rlo && y_cmp_i.shi_eq_rhi;
    contains  = !x_cmp_i.slo_gt_rlo && !x_cmp_i.slo_eq_rlo && x_cmp_i.shi_gt_rhi &&
                !y_cmp_i.slo_gt_rlo && !y_cmp_i.slo_eq_rlo && y_cmp_i.shi_gt_rhi;
    in_strict = x_cmp_i.slo_gt_rlo && !x_cmp_i.shi_gt_rhi && !x_cmp_i.shi_eq_rhi &&
                y_cmp_i.slo_gt_rlo && !y_cmp_i.shi_gt_rhi && !y_cmp_i.shi_eq_rhi;
    encl_s    = !x_cmp_i.slo_gt_rlo && (x_cmp_i.shi_gt_rhi || x_cmp_i.shi_eq_rhi) &&
                !y_cmp_i.slo_gt_rlo && (y_cmp_i.shi_gt_rhi || y_cmp_i.shi_eq_rhi);
    encl_r    = (x_cmp_i.slo_gt_rlo || x_cmp_i.slo_eq_rlo) && !x_cmp_i.shi_gt_rhi &&
                (y_cmp_i.slo_gt_rlo || y_cmp_i.slo_eq_rlo) && !y_cmp_i.shi_gt_rhi;
    covers    = encl_s && !contains && !equal;
    cov_by    = encl_r && !in_strict && !equal;

    rsp_o.is_disjoint       = !overlap;
    rsp_o.is_meet           = meet;
    rsp_o.is_strict_overlap = overlap && !(covers || contains || equal || in_strict ||
                                           cov_by || meet);
    rsp_o.is_covers         = covers;
    rsp_o.is_contains       = contains;
    rsp_o.is_equal          = equal;
    rsp_o.is_inside         = in_strict;
    rsp_o.is_covered_by     = cov_by;
    rsp_o.x_relation        = x_code_i;
    rsp_o.y_relation        = y_code_i;
  end

endmodule

[src/rect_topology_classifier_top.sv]
// Rectangle topology classifier.
// Timing: a request is captured in the input register, classified combinationally,
//   and registered with valid_o in the result register. The receiver cannot stall.
// Throughput: one request per cycle; busy_o is always low. The single input
//   register feeds the comparators, whose outputs go to a result register.
// Reset: asynchronous active-low rst_ni clears the valid flags only.
`include "rect_topology_classifier_top_defines.svh"
module rect_topology_classifier_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  rtc_pkg::req_t req_i,
  output logic          valid_o,
  output rtc_pkg::rsp_t rsp_o
);
  import rtc_pkg::*;

  req_t      stg_q;
  logic      stg_vld_q;
  rsp_t      rsp_d, rsp_q;
  logic      valid_q;
  axis_cmp_t x_cmp, y_cmp;
  rel_code_e x_code, y_code;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_vld_q <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      stg_vld_q <= start_i && !busy_o;
      valid_q   <= stg_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      stg_q <= req_i;
    end
    if (stg_vld_q) begin
      rsp_q <= rsp_d;
    end
  end

  rtc_axis_cmp u_x_cmp (
    .r_lo_i (stg_q.ref_x_low),
    .r_hi_i (stg_q.ref_x_high),
    .s_lo_i (stg_q.cand_x_low),
    .s_hi_i (stg_q.cand_x_high),
    .cmp_o  (x_cmp),
    .code_o (x_code)
  );

  rtc_axis_cmp u_y_cmp (
    .r_lo_i (stg_q.ref_y_low),
    .r_hi_i (stg_q.ref_y_high),
    .s_lo_i (stg_q.cand_y_low),
    .s_hi_i (stg_q.cand_y_high),
    .cmp_o  (y_cmp),
    .code_o (y_code)
  );

  rtc_classify u_classify (
    .x_cmp_i  (x_cmp),
    .y_cmp_i  (y_cmp),
    .x_code_i (x_code),
    .y_code_i (y_code),
    .rsp_o    (rsp_d)
  );

  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

  `RTC_ASSERT_NXT(a_req_to_stage, start_i && !busy_o, stg_vld_q, "request lost in stage")
  `RTC_ASSERT_NXT(a_stage_to_rsp, stg_vld_q, valid_o, "staged request not strobed")
  `RTC_ASSERT_IMP(a_disjoint_excl, valid_o && rsp_o.is_disjoint,
                  !rsp_o.is_meet && !rsp_o.is_strict_overlap, "disjoint with contact flag")
  `RTC_ASSERT_IMP(a_strict_excl, valid_o && rsp_o.is_contains,
                  !rsp_o.is_covers && !rsp_o.is_equal, "contains with covers or equal")

endmodule

[bench/tb_top.sv]
import rtc_pkg::*;

class rect_relation_board;
  rsp_t        expected_q[$];
  int unsigned errors;

  function new();
    errors = 0;
  endfunction

  static function rel_code_e axis_code(coord_t rlo, coord_t rhi, coord_t slo, coord_t shi);
    if (slo > rhi) return RelAfter;
    if (slo == rhi) return RelMetBy;
    if (shi > rhi && slo > rlo && slo < rhi) return RelOverlappedBy;
    if (shi > rhi && slo == rlo) return RelStartedBy;
    if (shi > rhi && slo < rlo) return RelContains;
    if (shi == rhi && slo > rlo) return RelFinishes;
    if (shi == rhi && slo == rlo) return RelEquals;
    if (shi == rhi && slo < rlo) return RelFinishedBy;
    if (shi < rhi && slo > rlo) return RelDuring;
    if (shi < rhi && slo == rlo) return RelStarts;
    if (shi < rhi && shi > rlo && slo < rlo) return RelOverlaps;
    if (shi == rlo) return RelMeets;
    if (shi < rlo) return RelBefore;
    return RelNone;
  endfunction

  function rsp_t classify(req_t rq);
    coord_t rlo[2], rhi[2], slo[2], shi[2];
    bit     overlap, meet, same, cont, insd, cov_loose, covby_loose;
    rsp_t   r;
    rlo[0] = rq.ref_x_low;   rlo[1] = rq.ref_y_low;
    rhi[0] = rq.ref_x_high;  rhi[1] = rq.ref_y_high;
    slo[0] = rq.cand_x_low;  slo[1] = rq.cand_y_low;
    shi[0] = rq.cand_x_high; shi[1] = rq.cand_y_high;
    overlap = 1'b1;
    meet = 1'b0;
    same = 1'b1;
    cont = 1'b1;
    insd = 1'b1;
    cov_loose = 1'b1;
    covby_loose = 1'b1;
    for (int a = 0; a < 2; a++) begin
      if (rlo[a] > shi[a] || slo[a] > rhi[a]) overlap = 1'b0;
      if (slo[a] == rhi[a] || rlo[a] == shi[a]) meet = 1'b1;
      if (slo[a] != rlo[a] || shi[a] != rhi[a]) same = 1'b0;
      if (!(slo[a] < rlo[a] && shi[a] > rhi[a])) cont = 1'b0;
      if (!(rlo[a] < slo[a] && rhi[a] > shi[a])) insd = 1'b0;
      if (!(slo[a] <= rlo[a] && shi[a] >= rhi[a])) cov_loose = 1'b0;
      if (!(rlo[a] <= slo[a] && rhi[a] >= shi[a])) covby_loose = 1'b0;
    end
    meet = meet && overlap;
    r.is_disjoint = !overlap;
    r.is_meet = meet;
    r.is_covers = cov_loose && !cont && !same;
    r.is_contains = cont;
    r.is_equal = same;
    r.is_inside = insd;
    r.is_covered_by = covby_loose && !insd && !same;
    r.is_strict_overlap = overlap && !(r.is_covers || cont || same || insd ||
                                       r.is_covered_by || meet);
    r.x_relation = axis_code(rlo[0], rhi[0], slo[0], shi[0]);
    r.y_relation = axis_code(rlo[1], rhi[1], slo[1], shi[1]);
    return r;
  endfunction

  function void note_request(req_t rq);
    expected_q.push_back(classify(rq));
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction

  function void cmp_field(string name, logic [3:0] exp_v, logic [3:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  function void check_result(rsp_t got);
    rsp_t exp_r;
    if (expected_q.size() == 0) begin
      $error("result strobe with no request pending");
      errors++;
      return;
    end
    exp_r = expected_q.pop_front();
    cmp_field("is_disjoint", exp_r.is_disjoint, got.is_disjoint);
    cmp_field("is_meet", exp_r.is_meet, got.is_meet);
    cmp_field("is_strict_overlap", exp_r.is_strict_overlap, got.is_strict_overlap);
    cmp_field("is_covers", exp_r.is_covers, got.is_covers);
    cmp_field("is_contains", exp_r.is_contains, got.is_contains);
    cmp_field("is_equal", exp_r.is_equal, got.is_equal);
    cmp_field("is_inside", exp_r.is_inside, got.is_inside);
    cmp_field("is_covered_by", exp_r.is_covered_by, got.is_covered_by);
    cmp_field("x_relation", exp_r.x_relation, got.x_relation);
    cmp_field("y_relation", exp_r.y_relation, got.y_relation);
  endfunction
endclass

module tb_top;

  localparam int unsigned RandomCount = 700;
  localparam int unsigned CycleLimit  = 200000;
  localparam coord_t      CoordMin    = 32'sh8000_0000;
  localparam coord_t      CoordMax    = 32'sh7fff_ffff;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  req_t req_i = '0;
  logic busy_o;
  logic valid_o;
  rsp_t rsp_o;

  rect_relation_board sb;
  int unsigned        cycles = 0;
  int unsigned        burst_left = 0;

  rect_topology_classifier_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .req_i  (req_i),
    .valid_o(valid_o),
    .rsp_o  (rsp_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) sb.check_result(rsp_o);
  end

  function automatic req_t make_req(coord_t rxl, coord_t ryl, coord_t rxh, coord_t ryh,
                                    coord_t cxl, coord_t cyl, coord_t cxh, coord_t cyh);
    req_t rq;
    rq.ref_x_low = rxl;   rq.ref_y_low = ryl;
    rq.ref_x_high = rxh;  rq.ref_y_high = ryh;
    rq.cand_x_low = cxl;  rq.cand_y_low = cyl;
    rq.cand_x_high = cxh; rq.cand_y_high = cyh;
    return rq;
  endfunction

  function automatic coord_t pick_base();
    case ($urandom_range(0, 3))
      0: return coord_t'($urandom);
      1: return CoordMin + coord_t'($urandom_range(0, 40));
      2: return CoordMax - coord_t'($urandom_range(0, 40));
      default: return coord_t'($urandom_range(0, 200)) - 32'sd100;
    endcase
  endfunction

  // one axis: reference and candidate interval drawn from a shared grid, or fully random when kind is 0
  task automatic gen_axis(output coord_t rl, output coord_t rh,
                          output coord_t sl, output coord_t sh);
    coord_t      base, step;
    int unsigned kind, i, j, k, l, t;
    kind = $urandom_range(0, 9);
    base = pick_base();
    step = ($urandom_range(0, 3) == 0) ? coord_t'($urandom) : coord_t'($urandom_range(1, 16));
    i = $urandom_range(0, 5);
    j = $urandom_range(0, 5);
    k = $urandom_range(0, 5);
    l = $urandom_range(0, 5);
    if (kind > 1) begin
      if (i > j) begin t = i; i = j; j = t; end
      if (k > l) begin t = k; k = l; l = t; end
    end
    rl = base + coord_t'(i) * step;
    rh = base + coord_t'(j) * step;
    sl = base + coord_t'(k) * step;
    sh = base + coord_t'(l) * step;
    if (kind == 0) begin
      rl = coord_t'($urandom);
      rh = coord_t'($urandom);
      sl = coord_t'($urandom);
      sh = coord_t'($urandom);
    end
  endtask

  task automatic send_request(req_t rq);
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 4);
      if ($urandom_range(0, 19) == 0) burst_left = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i <= rq;
    do @(posedge clk_i); while (busy_o);
    sb.note_request(rq);
  endtask

  initial begin
    req_t   directed_q[$];
    req_t   rq;
    coord_t ivl_lo[13], ivl_hi[13];
    coord_t rxl, rxh, ryl, ryh, cxl, cxh, cyl, cyh;
    sb = new();
    // candidate intervals against [0,10], one per interval code in order
    ivl_lo = '{11, 10, 5, 0, -5, 5, 0, -5, 2, 0, -5, -5, -10};
    ivl_hi = '{20, 20, 15, 15, 15, 10, 10, 10, 8, 5, 5, 0, -5};
    for (int n = 0; n < 13; n++) begin
      directed_q.push_back(make_req(0, 0, 10, 10, ivl_lo[n], ivl_lo[(n * 5) % 13],
                                    ivl_hi[n], ivl_hi[(n * 5) % 13]));
    end
    directed_q.push_back(make_req(2, 2, 8, 8, 0, 0, 10, 10));
    directed_q.push_back(make_req(0, 0, 10, 10, 0, -5, 12, 15));
    directed_q.push_back(make_req(0, 0, 10, 10, 0, 2, 8, 10));
    directed_q.push_back(make_req(0, 0, 10, 10, 10, 10, 20, 20));
    directed_q.push_back(make_req(10, 10, 0, 0, 2, 2, 8, 8));
    directed_q.push_back(make_req(0, 0, 10, 10, 8, 8, 2, 2));
    directed_q.push_back(make_req(CoordMin, CoordMin, CoordMax, CoordMax,
                                  CoordMin, CoordMin, CoordMax, CoordMax));
    directed_q.push_back(make_req(CoordMin, CoordMin, CoordMax, CoordMax, 0, 0, 1, 1));
    directed_q.push_back(make_req(CoordMin, CoordMin, CoordMin, CoordMin,
                                  CoordMax, CoordMax, CoordMax, CoordMax));
    directed_q.push_back(make_req(-1, -1, -1, -1, -1, -1, -1, -1));
    directed_q.push_back(make_req(CoordMax, CoordMax, CoordMin, CoordMin,
                                  CoordMin, CoordMax, CoordMax, CoordMin));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_q[n]) send_request(directed_q[n]);
    for (int n = 0; n < RandomCount; n++) begin
      gen_axis(rxl, rxh, cxl, cxh);
      gen_axis(ryl, ryh, cyl, cyh);
      rq = make_req(rxl, ryl, rxh, ryh, cxl, cyl, cxh, cyh);
      send_request(rq);
    end
    start_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
